// File: design/lru_open_handle_tracker_unit_macros.svh
// Assertion macros for the open-handle tracker.
`ifndef LRU_OPEN_HANDLE_TRACKER_UNIT_MACROS_SVH
`define LRU_OPEN_HANDLE_TRACKER_UNIT_MACROS_SVH

`ifndef SYNTH
`define LOHT_ASSERT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define LOHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define LOHT_ASSERT(lbl, clk, rst_n, ante, cons)
`define LOHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: design/loht_pkg.sv
// Shared types and constants of the open-handle tracker.
`timescale 1ns / 1ps
`default_nettype none
package loht_pkg;
	localparam int LEAVES_DEF = 64;
	localparam int KINDS = 3;
	localparam int STAMP_W = 64;
	localparam int COUNT_W = 8;
	localparam int LEAF_PORT_W = 6;
	localparam int KIND_PORT_W = 2;

	localparam logic [COUNT_W-1:0] MAX_OPEN_RST = 8'd16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
	localparam logic [KIND_PORT_W-1:0] KIND_MAX = 2'd2;

	typedef enum logic [0:0] {
		OP_ACCESS = 1'b0,
		OP_CLOSE_ALL = 1'b1
	} opcode_t;

	typedef struct packed {
		logic is_open;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic start;
		logic sample;
	} scan_ctl_t;
endpackage
`default_nettype wire

// File: design/loht_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module loht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// File: design/loht_scan.sv
// Running oldest-stamp search over a stream of memory entries.
`timescale 1ns / 1ps
`default_nettype none
module loht_scan import loht_pkg::*; #(
	parameter int LEAVES = LEAVES_DEF,
	localparam int ENTRIES = KINDS * LEAVES,
	localparam int ENTRY_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int LEAF_W = (LEAVES > 1) ? $clog2(LEAVES) : 1
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire scan_ctl_t ctl,
	input wire entry_t entry,
	input wire logic [ENTRY_W-1:0] addr,
	input wire logic [LEAF_W-1:0] leaf,
	input wire logic [KIND_PORT_W-1:0] kind,
	output logic found,
	output logic [ENTRY_W-1:0] best_addr,
	output logic [LEAF_W-1:0] best_leaf,
	output logic [KIND_PORT_W-1:0] best_kind
);
	logic found_q;
	logic [STAMP_W-1:0] best_stamp_q;
	logic [ENTRY_W-1:0] best_addr_q;
	logic [LEAF_W-1:0] best_leaf_q;
	logic [KIND_PORT_W-1:0] best_kind_q;
	logic take;

	assign take = ctl.sample && entry.is_open && (!found_q || (entry.stamp < best_stamp_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.start) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_stamp_q <= entry.stamp;
			best_addr_q <= addr;
			best_leaf_q <= leaf;
			best_kind_q <= kind;
		end
	end

	assign found = found_q;
	assign best_addr = best_addr_q;
	assign best_leaf = best_leaf_q;
	assign best_kind = best_kind_q;
endmodule
`default_nettype wire

// File: design/lru_open_handle_tracker_unit.sv
// Open-handle tracker: per-entry state memory, LRU eviction scan, result register.
// Ignored access: straight to emit. Hit: look, emit. Open below the limit: look, open, emit.
// An access that needs eviction reads every entry once: look, scan, tail, evict, open, emit.
// Close all rewrites every entry, then emits. One item at a time, plus any output stall.
// One state-memory entry per cycle sets both the scan and the clear length.
// After reset a clearing pass over every entry runs before the first item is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "lru_open_handle_tracker_unit_macros.svh"
module lru_open_handle_tracker_unit import loht_pkg::*; #(
	parameter int LEAVES = LEAVES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [COUNT_W-1:0] cfg_wdata,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic opcode,
	input wire logic [KIND_PORT_W-1:0] handle_kind,
	input wire logic [LEAF_PORT_W-1:0] leaf_index,
	output logic out_valid,
	input wire logic out_ready,
	output logic was_open,
	output logic evicted,
	output logic [KIND_PORT_W-1:0] evicted_kind,
	output logic [LEAF_PORT_W-1:0] evicted_leaf,
	output logic [COUNT_W-1:0] open_count
);
	localparam int ENTRIES = KINDS * LEAVES;
	localparam int ENTRY_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int LEAF_W = (LEAVES > 1) ? $clog2(LEAVES) : 1;
	localparam logic [ENTRY_W-1:0] LAST_ENTRY = ENTRY_W'(ENTRIES - 1);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_SCAN,
		S_TAIL,
		S_EVICT,
		S_OPEN,
		S_EMIT
	} state_t;

	state_t state_q;
	logic close_q;
	logic [COUNT_W-1:0] max_open_q;
	logic [COUNT_W-1:0] total_q;
	logic [STAMP_W-1:0] counter_q;
	logic [ENTRY_W-1:0] scan_addr_q;
	logic [LEAF_W-1:0] scan_leaf_q;
	logic [KIND_PORT_W-1:0] scan_kind_q;
	logic sample_s1;
	logic [ENTRY_W-1:0] tag_addr_s1;
	logic [LEAF_W-1:0] tag_leaf_s1;
	logic [KIND_PORT_W-1:0] tag_kind_s1;
	logic [ENTRY_W-1:0] idx_q;
	logic res_was_q;
	logic res_ev_q;
	logic [KIND_PORT_W-1:0] res_kind_q;
	logic [LEAF_PORT_W-1:0] res_leaf_q;
	logic out_valid_q;
	logic out_was_q;
	logic out_ev_q;
	logic [KIND_PORT_W-1:0] out_kind_q;
	logic [LEAF_PORT_W-1:0] out_leaf_q;
	logic [COUNT_W-1:0] out_count_q;

	logic accept;
	logic bad_item;
	logic [7:0] idx_full;
	logic [ENTRY_W-1:0] in_idx;
	logic ram_we;
	logic [ENTRY_W-1:0] ram_waddr;
	entry_t ram_wdata;
	logic [ENTRY_W-1:0] ram_raddr;
	logic [$bits(entry_t)-1:0] ram_rdata;
	entry_t rd_entry;
	scan_ctl_t scan_ctl;
	logic best_found;
	logic [ENTRY_W-1:0] best_addr;
	logic [LEAF_W-1:0] best_leaf;
	logic [KIND_PORT_W-1:0] best_kind;
	logic [LEAF_W+LEAF_PORT_W-1:0] best_leaf_ext;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign bad_item = (handle_kind > KIND_MAX) || (32'(leaf_index) >= 32'(LEAVES));
	assign idx_full = {1'b0, leaf_index, 1'b0} + {2'b0, leaf_index} + {6'b0, handle_kind};
	assign in_idx = ENTRY_W'(idx_full);
	assign rd_entry = entry_t'(ram_rdata);
	assign best_leaf_ext = {{LEAF_PORT_W{1'b0}}, best_leaf};
	assign ram_raddr = (state_q == S_SCAN) ? scan_addr_q : in_idx;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '{is_open: 1'b1, stamp: counter_q};
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = scan_addr_q;
				ram_wdata = '{is_open: 1'b0, stamp: '0};
			end
			S_LOOK: begin
				ram_we = rd_entry.is_open;
			end
			S_EVICT: begin
				ram_we = best_found;
				ram_waddr = best_addr;
				ram_wdata = '{is_open: 1'b0, stamp: '0};
			end
			S_OPEN: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign scan_ctl = '{start: (state_q == S_LOOK), sample: sample_s1};

	loht_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	loht_scan #(
		.LEAVES(LEAVES)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(scan_ctl),
		.entry(rd_entry),
		.addr(tag_addr_s1),
		.leaf(tag_leaf_s1),
		.kind(tag_kind_s1),
		.found(best_found),
		.best_addr(best_addr),
		.best_leaf(best_leaf),
		.best_kind(best_kind)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_open_q <= MAX_OPEN_RST;
		end else if (cfg_we) begin
			max_open_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			close_q <= 1'b0;
			total_q <= '0;
			counter_q <= '0;
			scan_addr_q <= '0;
			scan_leaf_q <= '0;
			scan_kind_q <= '0;
			sample_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			sample_s1 <= (state_q == S_SCAN);
			if (out_valid_q && out_ready && (state_q != S_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					scan_addr_q <= scan_addr_q + 1'b1;
					if (scan_addr_q == LAST_ENTRY) begin
						state_q <= close_q ? S_EMIT : S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (opcode == OP_CLOSE_ALL) begin
							close_q <= 1'b1;
							total_q <= '0;
							scan_addr_q <= '0;
							state_q <= S_CLEAR;
						end else if (bad_item) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_LOOK;
						end
					end
				end
				S_LOOK: begin
					if (rd_entry.is_open) begin
						counter_q <= counter_q + 1'b1;
						state_q <= S_EMIT;
					end else if (total_q >= max_open_q) begin
						scan_addr_q <= '0;
						scan_leaf_q <= '0;
						scan_kind_q <= '0;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_OPEN;
					end
				end
				S_SCAN: begin
					scan_addr_q <= scan_addr_q + 1'b1;
					if (scan_kind_q == KIND_MAX) begin
						scan_kind_q <= '0;
						scan_leaf_q <= scan_leaf_q + 1'b1;
					end else begin
						scan_kind_q <= scan_kind_q + 1'b1;
					end
					if (scan_addr_q == LAST_ENTRY) begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					state_q <= S_EVICT;
				end
				S_EVICT: begin
					if (best_found && (total_q != '0)) begin
						total_q <= total_q - 1'b1;
					end
					state_q <= S_OPEN;
				end
				S_OPEN: begin
					counter_q <= counter_q + 1'b1;
					if (total_q < COUNT_MAX) begin
						total_q <= total_q + 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						close_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		tag_addr_s1 <= scan_addr_q;
		tag_leaf_s1 <= scan_leaf_q;
		tag_kind_s1 <= scan_kind_q;
		if (accept) begin
			idx_q <= in_idx;
			res_was_q <= 1'b0;
			res_ev_q <= 1'b0;
			res_kind_q <= '0;
			res_leaf_q <= '0;
		end
		if (state_q == S_LOOK) begin
			res_was_q <= rd_entry.is_open;
		end
		if ((state_q == S_EVICT) && best_found) begin
			res_ev_q <= 1'b1;
			res_kind_q <= best_kind;
			res_leaf_q <= best_leaf_ext[LEAF_PORT_W-1:0];
		end
		if ((state_q == S_EMIT) && (!out_valid_q || out_ready)) begin
			out_was_q <= res_was_q;
			out_ev_q <= res_ev_q;
			out_kind_q <= res_kind_q;
			out_leaf_q <= res_leaf_q;
			out_count_q <= total_q;
		end
	end

	assign out_valid = out_valid_q;
	assign was_open = out_was_q;
	assign evicted = out_ev_q;
	assign evicted_kind = out_kind_q;
	assign evicted_leaf = out_leaf_q;
	assign open_count = out_count_q;

	`LOHT_ASSERT(a_scan_no_write, clk, arst_n, state_q == S_SCAN, !ram_we)
	`LOHT_ASSERT(a_hit_no_evict, clk, arst_n, out_valid && was_open, !evicted)
	`LOHT_ASSERT(a_evict_count, clk, arst_n, out_valid && evicted, open_count != '0)
	`LOHT_ASSERT(a_rise_from_emit, clk, arst_n, $rose(out_valid), $past(state_q == S_EMIT))
	`LOHT_ASSERT_NEXT(a_look_follows, clk, arst_n, accept && (opcode == OP_ACCESS) && !bad_item,
		state_q == S_LOOK)
endmodule
`default_nettype wire

// File: dv/testbench.sv
// Testbench for the open-handle tracker: LRU prediction, handshake driver and result monitor.
`timescale 1ns / 1ps
module testbench;
	import loht_pkg::*;

	localparam int ENTRY_CNT = KINDS * LEAVES_DEF;
	localparam int PHASE_ITEMS = 170;

	typedef struct packed {
		opcode_t op;
		logic [KIND_PORT_W-1:0] kind;
		logic [LEAF_PORT_W-1:0] leaf;
	} tracker_req_t;

	typedef struct packed {
		logic was_open;
		logic evicted;
		logic [KIND_PORT_W-1:0] ev_kind;
		logic [LEAF_PORT_W-1:0] ev_leaf;
		logic [COUNT_W-1:0] count;
	} tracker_resp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [COUNT_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic opcode = 1'b0;
	logic [KIND_PORT_W-1:0] handle_kind = '0;
	logic [LEAF_PORT_W-1:0] leaf_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic was_open;
	logic evicted;
	logic [KIND_PORT_W-1:0] evicted_kind;
	logic [LEAF_PORT_W-1:0] evicted_leaf;
	logic [COUNT_W-1:0] open_count;

	logic quiet = 1'b0;

	tracker_req_t cmd_q[$];
	tracker_resp_t expected_resp_q[$];

	bit is_open [ENTRY_CNT];
	logic [STAMP_W-1:0] use_stamp [ENTRY_CNT];
	int open_total = 0;
	logic [STAMP_W-1:0] use_clock = '0;
	logic [COUNT_W-1:0] limit_cfg = MAX_OPEN_RST;

	int beats_in = 0;
	int beats_out = 0;
	int failures = 0;
	int evictions = 0;
	int reopen_hits = 0;
	int limit_writes = 0;
	int tx_gap = 0;
	int rx_gap = 0;
	int rx_hold = 0;
	bit drain_hold = 1'b0;
	int hot_base = 0;

	lru_open_handle_tracker_unit #(.LEAVES(LEAVES_DEF)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.handle_kind(handle_kind),
		.leaf_index(leaf_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.was_open(was_open),
		.evicted(evicted),
		.evicted_kind(evicted_kind),
		.evicted_leaf(evicted_leaf),
		.open_count(open_count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic tracker_resp_t predict_lru(tracker_req_t req);
		tracker_resp_t res;
		int slot;
		int victim;
		bit found;
		res = '0;
		if (req.op == OP_CLOSE_ALL) begin
			for (int i = 0; i < ENTRY_CNT; i++) is_open[i] = 1'b0;
			open_total = 0;
			return res;
		end
		if (req.kind > KIND_MAX || int'(req.leaf) >= LEAVES_DEF) begin
			res.count = open_total[COUNT_W-1:0];
			return res;
		end
		slot = int'(req.leaf) * KINDS + int'(req.kind);
		if (is_open[slot]) begin
			use_stamp[slot] = use_clock;
			use_clock++;
			res.was_open = 1'b1;
			res.count = open_total[COUNT_W-1:0];
			reopen_hits++;
			return res;
		end
		if (open_total >= int'(limit_cfg)) begin
			found = 1'b0;
			victim = 0;
			for (int i = 0; i < ENTRY_CNT; i++) begin
				if (is_open[i] && (!found || use_stamp[i] < use_stamp[victim])) begin
					found = 1'b1;
					victim = i;
				end
			end
			if (found) begin
				is_open[victim] = 1'b0;
				if (open_total > 0) open_total--;
				res.evicted = 1'b1;
				res.ev_kind = KIND_PORT_W'(victim % KINDS);
				res.ev_leaf = LEAF_PORT_W'(victim / KINDS);
				evictions++;
			end
		end
		is_open[slot] = 1'b1;
		if (open_total < int'(COUNT_MAX)) open_total++;
		use_stamp[slot] = use_clock;
		use_clock++;
		res.count = open_total[COUNT_W-1:0];
		return res;
	endfunction

	function automatic tracker_req_t random_req();
		tracker_req_t req;
		int r;
		r = $urandom_range(0, 99);
		req.op = OP_ACCESS;
		req.kind = KIND_PORT_W'($urandom_range(0, 2));
		req.leaf = LEAF_PORT_W'($urandom_range(0, 63));
		if ($urandom_range(0, 19) == 0) hot_base = $urandom_range(0, 63);
		if (r < 3) begin
			req.op = OP_CLOSE_ALL;
			req.kind = KIND_PORT_W'($urandom_range(0, 3));
		end else if (r < 7) begin
			req.kind = KIND_MAX + 2'd1;
		end else if (r < 60) begin
			req.leaf = LEAF_PORT_W'(hot_base + $urandom_range(0, 3));
		end
		return req;
	endfunction

	task automatic push_req(opcode_t op, int kind, int leaf);
		tracker_req_t req;
		req.op = op;
		req.kind = KIND_PORT_W'(kind);
		req.leaf = LEAF_PORT_W'(leaf);
		cmd_q.push_back(req);
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (cmd_q.size() != 0 || in_valid || expected_resp_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= COUNT_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_cfg = COUNT_W'(value);
		limit_writes++;
	endtask

	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			expected_resp_q.push_back(predict_lru(cmd_q.pop_front()));
			beats_in++;
			if (beats_in == 700) drain_hold = 1'b1;
		end
		if (in_valid && !in_ready) begin
		end else if (!arst_n || tx_gap > 0 || drain_hold || cmd_q.size() == 0) begin
			in_valid <= 1'b0;
			if (tx_gap > 0) tx_gap--;
			if (drain_hold && expected_resp_q.size() == 0) drain_hold = 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			tx_gap = $urandom_range(0, 4);
		end else begin
			in_valid <= 1'b1;
			opcode <= cmd_q[0].op;
			handle_kind <= cmd_q[0].kind;
			leaf_index <= cmd_q[0].leaf;
		end
	end

	always @(posedge clk) begin
		tracker_resp_t exp_r;
		tracker_resp_t got_r;
		if (out_valid && out_ready) begin
			got_r = {was_open, evicted, evicted_kind, evicted_leaf, open_count};
			beats_out++;
			if (beats_out % 500 == 250) rx_hold = 400;
			if (expected_resp_q.size() == 0) begin
				failures++;
				$display("%0t: unexpected result %p", $time, got_r);
			end else begin
				exp_r = expected_resp_q.pop_front();
				if (got_r.was_open !== exp_r.was_open) begin
					failures++;
					$display("%0t: was_open expected %0d actual %0d", $time,
						exp_r.was_open, got_r.was_open);
				end
				if (got_r.evicted !== exp_r.evicted) begin
					failures++;
					$display("%0t: evicted expected %0d actual %0d", $time,
						exp_r.evicted, got_r.evicted);
				end
				if (got_r.ev_kind !== exp_r.ev_kind) begin
					failures++;
					$display("%0t: evicted_kind expected %0d actual %0d", $time,
						exp_r.ev_kind, got_r.ev_kind);
				end
				if (got_r.ev_leaf !== exp_r.ev_leaf) begin
					failures++;
					$display("%0t: evicted_leaf expected %0d actual %0d", $time,
						exp_r.ev_leaf, got_r.ev_leaf);
				end
				if (got_r.count !== exp_r.count) begin
					failures++;
					$display("%0t: open_count expected %0d actual %0d", $time,
						exp_r.count, got_r.count);
				end
			end
		end
		if (rx_hold > 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			rx_gap = $urandom_range(0, 4);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		#30000000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int limits [9];
		limits = '{1, 192, 8, 255, 40, 3, 100, 192, 16};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		write_limit(2);
		push_req(OP_ACCESS, 0, 0);
		push_req(OP_ACCESS, 1, 0);
		push_req(OP_ACCESS, 2, 63);
		push_req(OP_ACCESS, 1, 0);
		push_req(OP_ACCESS, 0, 63);
		push_req(OP_ACCESS, 3, 63);
		push_req(OP_CLOSE_ALL, 3, 63);
		push_req(OP_ACCESS, 3, 0);
		push_req(OP_ACCESS, 2, 63);
		push_req(OP_CLOSE_ALL, 0, 0);
		wait_idle();

		write_limit(0);
		push_req(OP_ACCESS, 1, 5);
		push_req(OP_ACCESS, 2, 5);
		push_req(OP_ACCESS, 2, 5);
		push_req(OP_CLOSE_ALL, 0, 0);
		wait_idle();

		write_limit(192);
		push_req(OP_ACCESS, 0, 10);
		push_req(OP_ACCESS, 1, 11);
		push_req(OP_ACCESS, 2, 12);
		push_req(OP_ACCESS, 0, 13);
		push_req(OP_ACCESS, 1, 14);
		wait_idle();

		write_limit(1);
		push_req(OP_ACCESS, 0, 40);
		push_req(OP_ACCESS, 1, 40);
		push_req(OP_ACCESS, 1, 40);
		wait_idle();

		foreach (limits[p]) begin
			write_limit(limits[p]);
			if (p == $size(limits) - 1) quiet <= 1'b1;
			repeat (PHASE_ITEMS) cmd_q.push_back(random_req());
			wait_idle();
		end

		repeat (3 * LEAVES_DEF + 8) @(posedge clk);
		if (expected_resp_q.size() != 0) begin
			failures++;
			$display("%0t: %0d results never arrived", $time, expected_resp_q.size());
		end
		$display("Run covered %0d requests over %0d limit settings.", beats_in, limit_writes);
		$display("Predicted %0d evictions and %0d hits on open handles.", evictions,
			reopen_hits);
		if (failures == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// File: filelist.f
+incdir+design
design/loht_pkg.sv
design/loht_ram.sv
design/loht_scan.sv
design/lru_open_handle_tracker_unit.sv
dv/testbench.sv
